@@ sv/nsf_bank_switch_mapper_defines.svh @@
// ---------------------------------------------------------------------------
// NSF bank switch mapper assertion macros
// Shared concurrent assertion wrappers, removable with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef NSF_BANK_SWITCH_MAPPER_DEFINES_SVH
`define NSF_BANK_SWITCH_MAPPER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define NSBM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nsbm assertion failed");
// next-cycle implication
`define NSBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nsbm assertion failed");
`else
`define NSBM_ASSERT_NOW(label, clk, rst, ante, cons)
`define NSBM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ sv/nsbm_pkg.sv @@
// ---------------------------------------------------------------------------
// NSF bank switch mapper package
// Address map constants, codes and shared types.
// ---------------------------------------------------------------------------
package nsbm_pkg;

  // work RAM size in bytes; power of two, 1024 to 8192
  localparam int RamBytes = 8192;
  localparam int RamAw    = $clog2(RamBytes);
  localparam int NumBanks = 8;
  localparam int BankAw   = $clog2(NumBanks);

  localparam logic [15:0] BankLo  = 16'h5000;
  localparam logic [15:0] BankHi  = 16'h5FFF;
  localparam logic [15:0] RamLo   = 16'h6000;
  localparam logic [15:0] RomLo   = 16'h8000;
  localparam logic [15:0] VecLo   = 16'hFFFA;
  localparam logic [15:0] RomBaseRst = 16'hFFFF;

  localparam logic Cmd_Read  = 1'b0;
  localparam logic Cmd_Write = 1'b1;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNotCart = 2'd1;
  localparam logic [1:0] StRomWr   = 2'd2;

  localparam logic [1:0] RegNone = 2'd0;
  localparam logic [1:0] RegBank = 2'd1;
  localparam logic [1:0] RegRam  = 2'd2;
  localparam logic [1:0] RegRom  = 2'd3;

  typedef logic [NumBanks-1:0][7:0] bank_file_t;

  typedef struct packed {
    logic [1:0]       region;
    logic [BankAw-1:0] bank_idx;
    logic [RamAw-1:0] ram_idx;
    logic [7:0]       rdata;
    logic [1:0]       status;
    logic             rom_fetch;
    logic [20:0]      mapped_addr;
  } dec_t;

endpackage

@@ sv/nsbm_ifs.sv @@
// ---------------------------------------------------------------------------
// NSF bank switch mapper channels
// Valid/ready channels for bus requests, responses and the base register.
// ---------------------------------------------------------------------------
interface nsbm_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] address;
  logic [7:0]  wdata;
  modport source (output valid, cmd, address, wdata, input ready);
  modport sink   (input valid, cmd, address, wdata, output ready);
endinterface

interface nsbm_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rdata;
  logic [1:0]  status;
  logic        rom_fetch;
  logic [20:0] mapped_addr;
  modport source (output valid, rdata, status, rom_fetch, mapped_addr, input ready);
  modport sink   (input valid, rdata, status, rom_fetch, mapped_addr, output ready);
endinterface

interface nsbm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ sv/nsbm_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module nsbm_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/nsbm_decode.sv @@
// ---------------------------------------------------------------------------
// NSF bank switch mapper decode
// Region decode, bank register read and ROM address translation.
// ---------------------------------------------------------------------------
module nsbm_decode (
  input  logic                cmd,
  input  logic [15:0]         address,
  input  nsbm_pkg::bank_file_t banks,
  input  logic                banking_on,
  input  logic [15:0]         rom_base,
  output nsbm_pkg::dec_t      dec
);

  logic [1:0]                 region;
  logic [nsbm_pkg::BankAw-1:0] bidx;
  logic [7:0]                 bval;
  logic [15:0]                roff;
  logic [20:0]                sum;

  always_comb begin
    if (address < nsbm_pkg::BankLo) begin
      region = nsbm_pkg::RegNone;
    end else if (address <= nsbm_pkg::BankHi) begin
      region = nsbm_pkg::RegBank;
    end else if (address < nsbm_pkg::RomLo) begin
      region = nsbm_pkg::RegRam;
    end else begin
      region = nsbm_pkg::RegRom;
    end
  end

  // one read port on the bank file
  assign bidx = (region == nsbm_pkg::RegBank) ? address[nsbm_pkg::BankAw-1:0]
                                              : address[12 +: nsbm_pkg::BankAw];
  assign bval = banks[bidx];
  assign roff = address - nsbm_pkg::RamLo;
  assign sum  = 21'(rom_base) + {1'b0, bval, address[11:0]};

  always_comb begin
    dec.region      = region;
    dec.bank_idx    = bidx;
    dec.ram_idx     = roff[nsbm_pkg::RamAw-1:0];
    dec.rdata       = 8'd0;
    dec.status      = nsbm_pkg::StOk;
    dec.rom_fetch   = 1'b0;
    dec.mapped_addr = 21'd0;
    case (region)
      nsbm_pkg::RegNone: begin
        dec.status = nsbm_pkg::StNotCart;
      end
      nsbm_pkg::RegBank: begin
        if (cmd == nsbm_pkg::Cmd_Read) begin
          dec.rdata = bval;
        end
      end
      nsbm_pkg::RegRam: begin
      end
      nsbm_pkg::RegRom: begin
        if (cmd == nsbm_pkg::Cmd_Write) begin
          dec.status = nsbm_pkg::StRomWr;
        end else begin
          dec.rom_fetch = 1'b1;
          if (banking_on && address < nsbm_pkg::VecLo) begin
            dec.mapped_addr = sum;
          end else begin
            dec.mapped_addr = 21'(address);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/nsf_bank_switch_mapper.sv @@
// ---------------------------------------------------------------------------
// NSF bank switch mapper
// Cartridge bus: bank registers, work RAM and ROM address translation.
// ---------------------------------------------------------------------------
// Takes one bus request per cycle unless held by the RAM sweep or by
// back-pressure; a response passes a stage register and then the output
// register. After reset the work RAM is swept to zero, one byte a cycle,
// over all RamBytes (8192) bytes, during which no request is accepted;
// base register writes are taken at any time. Requests go to the RAM and
// bank file when accepted, so a read right after a write sees the new byte.
`include "nsf_bank_switch_mapper_defines.svh"

module nsf_bank_switch_mapper (
  input logic         clk,
  input logic         rst,
  nsbm_req_if.sink    req,
  nsbm_rsp_if.source  rsp,
  nsbm_cfg_if.sink    cfg
);

  nsbm_pkg::dec_t       dec;
  nsbm_pkg::bank_file_t banks;
  logic                 banking_on;
  logic [15:0]          rom_base;
  logic                 clearing;
  logic [nsbm_pkg::RamAw-1:0] clr_idx;

  logic                 acc;
  logic                 load_out;
  logic                 ram_we;
  logic                 ram_re;
  logic [nsbm_pkg::RamAw-1:0] ram_waddr;
  logic [7:0]           ram_wdata;
  logic [7:0]           ram_q;

  logic                 v1;
  logic                 s1_ram;
  logic [7:0]           s1_rdata;
  logic [1:0]           s1_status;
  logic                 s1_fetch;
  logic [20:0]          s1_mapped;

  logic                 ovalid;

  nsbm_decode u_decode (
    .cmd        (req.cmd),
    .address    (req.address),
    .banks      (banks),
    .banking_on (banking_on),
    .rom_base   (rom_base),
    .dec        (dec)
  );

  assign load_out  = v1 && (!ovalid || rsp.ready);
  assign req.ready = !clearing && (!v1 || load_out);
  assign acc       = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign ram_we    = clearing ||
                     (acc && dec.region == nsbm_pkg::RegRam && req.cmd == nsbm_pkg::Cmd_Write);
  assign ram_re    = acc && dec.region == nsbm_pkg::RegRam && req.cmd == nsbm_pkg::Cmd_Read;
  assign ram_waddr = clearing ? clr_idx : dec.ram_idx;
  assign ram_wdata = clearing ? 8'd0 : req.wdata;

  nsbm_ram #(
    .Width (8),
    .Depth (nsbm_pkg::RamBytes)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (dec.ram_idx),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == nsbm_pkg::RamAw'(nsbm_pkg::RamBytes - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_base <= nsbm_pkg::RomBaseRst;
    end else if (cfg.valid) begin
      rom_base <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      banking_on <= 1'b0;
      for (int i = 0; i < nsbm_pkg::NumBanks; i++) begin
        banks[i] <= 8'(i);
      end
    end else if (acc && dec.region == nsbm_pkg::RegBank && req.cmd == nsbm_pkg::Cmd_Write) begin
      banking_on          <= 1'b1;
      banks[dec.bank_idx] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (acc) begin
      v1 <= 1'b1;
    end else if (load_out) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ram    <= (dec.region == nsbm_pkg::RegRam) && (req.cmd == nsbm_pkg::Cmd_Read);
      s1_rdata  <= dec.rdata;
      s1_status <= dec.status;
      s1_fetch  <= dec.rom_fetch;
      s1_mapped <= dec.mapped_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (load_out) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.rdata       <= s1_ram ? ram_q : s1_rdata;
      rsp.status      <= s1_status;
      rsp.rom_fetch   <= s1_fetch;
      rsp.mapped_addr <= s1_mapped;
    end
  end

  assign rsp.valid = ovalid;

  `NSBM_ASSERT_NOW(a_clear_idle, clk, rst, clearing, !v1 && !ovalid)
  `NSBM_ASSERT_NEXT(a_bank_on, clk, rst,
    acc && dec.region == nsbm_pkg::RegBank && req.cmd == nsbm_pkg::Cmd_Write, banking_on)
  `NSBM_ASSERT_NOW(a_err_zero, clk, rst, rsp.valid && rsp.status != nsbm_pkg::StOk,
    rsp.rdata == 8'd0 && !rsp.rom_fetch && rsp.mapped_addr == 21'd0)
  `NSBM_ASSERT_NOW(a_fetch_clean, clk, rst, rsp.valid && rsp.rom_fetch,
    rsp.rdata == 8'd0 && rsp.status == nsbm_pkg::StOk)

endmodule
